// ----- src/wxyph_pkg.sv -----
// shared types and constants for the windowed xy profile histogram
package wxyph_pkg;

    localparam int POS_W   = 16;
    localparam int SCALE_W = 4;
    localparam int HALF_W  = 7;
    localparam int BIN_W   = 7;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W   = 32;
    localparam int PROD_W  = POS_W + SCALE_W + 1;
    localparam int MAG_W   = POS_W + SCALE_W;
    localparam int RND_W   = MAG_W - 8;
    localparam int HIT_IDX_W = HALF_W + 1;
    localparam logic [MAG_W-1:0] ROUND_HALF = MAG_W'(128);

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_Y = 2'd2;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd5;
    localparam logic [HALF_W-1:0]  HALF_RESET  = 7'd50;

    localparam logic KIND_HIT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef struct packed {
        logic capture;
        logic mul;
        logic bin;
        logic rd;
        logic commit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } stat_t;

endpackage

// ----- src/wxyph_dp.sv -----
// datapath: config registers, scaling and rounding, profile memories, output registers
module wxyph_dp #(
    parameter int BINS       = 128,
    parameter int COUNT_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wxyph_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wxyph_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                kind,
    input  logic signed [wxyph_pkg::POS_W-1:0]  x_pos,
    input  logic signed [wxyph_pkg::POS_W-1:0]  y_pos,
    input  logic [wxyph_pkg::BIN_W-1:0]         bin_index,
    output logic                                accepted,
    output logic [wxyph_pkg::OUT_W-1:0]         x_count,
    output logic [wxyph_pkg::OUT_W-1:0]         y_count,
    input  wxyph_pkg::cmd_t                     cmd,
    output wxyph_pkg::stat_t                    stat
);

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int OUT_W = wxyph_pkg::OUT_W;

    logic [wxyph_pkg::SCALE_W-1:0] scale_reg;
    logic [wxyph_pkg::HALF_W-1:0]  half_x_reg;
    logic [wxyph_pkg::HALF_W-1:0]  half_y_reg;

    logic                                kind_reg;
    logic signed [wxyph_pkg::POS_W-1:0]  x_reg;
    logic signed [wxyph_pkg::POS_W-1:0]  y_reg;
    logic [wxyph_pkg::BIN_W-1:0]         bin_reg;

    logic signed [wxyph_pkg::PROD_W-1:0] px_reg;
    logic signed [wxyph_pkg::PROD_W-1:0] py_reg;
    logic signed [wxyph_pkg::PROD_W-1:0] px_next;
    logic signed [wxyph_pkg::PROD_W-1:0] py_next;

    logic [wxyph_pkg::HIT_IDX_W:0] bx;
    logic [wxyph_pkg::HIT_IDX_W:0] by;
    logic                          hit_ok;
    logic                          rd_ok;

    logic [AW-1:0] x_addr_reg;
    logic [AW-1:0] y_addr_reg;
    logic          ok_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [COUNT_BITS-1:0] x_mem [BINS];
    logic [COUNT_BITS-1:0] y_mem [BINS];
    logic [COUNT_BITS-1:0] x_rd_reg;
    logic [COUNT_BITS-1:0] y_rd_reg;
    logic [COUNT_BITS-1:0] x_inc;
    logic [COUNT_BITS-1:0] y_inc;
    logic [OUT_W-1:0]      x_rep;
    logic [OUT_W-1:0]      y_rep;

    logic                  mem_we;
    logic                  hit_we;
    logic [AW-1:0]         x_wr_addr;
    logic [AW-1:0]         y_wr_addr;
    logic [COUNT_BITS-1:0] x_wdata;
    logic [COUNT_BITS-1:0] y_wdata;

    logic             accepted_reg;
    logic [OUT_W-1:0] x_count_reg;
    logic [OUT_W-1:0] y_count_reg;

    // returns {in window, bin index}
    function automatic logic [wxyph_pkg::HIT_IDX_W:0] bin_of(
        input logic signed [wxyph_pkg::PROD_W-1:0] p,
        input logic [wxyph_pkg::HALF_W-1:0]        h
    );
        logic [wxyph_pkg::PROD_W-1:0]    mag_full;
        logic [wxyph_pkg::MAG_W-1:0]     sum;
        logic [wxyph_pkg::RND_W-1:0]     r;
        logic                            in_win;
        logic [wxyph_pkg::HIT_IDX_W-1:0] idx;
        mag_full = p[wxyph_pkg::PROD_W-1] ? wxyph_pkg::PROD_W'(-p) : wxyph_pkg::PROD_W'(p);
        sum      = mag_full[wxyph_pkg::MAG_W-1:0] + wxyph_pkg::ROUND_HALF;
        r        = sum[wxyph_pkg::MAG_W-1:8];
        in_win   = r < wxyph_pkg::RND_W'(h);
        if (p[wxyph_pkg::PROD_W-1])
        begin
            idx = wxyph_pkg::HIT_IDX_W'(h) - wxyph_pkg::HIT_IDX_W'(r);
        end
        else
        begin
            idx = wxyph_pkg::HIT_IDX_W'(h) + wxyph_pkg::HIT_IDX_W'(r);
        end
        return {in_win, idx};
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= wxyph_pkg::SCALE_RESET;
            half_x_reg <= wxyph_pkg::HALF_RESET;
            half_y_reg <= wxyph_pkg::HALF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                wxyph_pkg::CFG_SCALE:  scale_reg  <= cfg_data[wxyph_pkg::SCALE_W-1:0];
                wxyph_pkg::CFG_HALF_X: half_x_reg <= cfg_data[wxyph_pkg::HALF_W-1:0];
                wxyph_pkg::CFG_HALF_Y: half_y_reg <= cfg_data[wxyph_pkg::HALF_W-1:0];
                default: ;
            endcase
        end
    end

    assign px_next = x_reg * $signed({1'b0, scale_reg});
    assign py_next = y_reg * $signed({1'b0, scale_reg});

    assign bx     = bin_of(px_reg, half_x_reg);
    assign by     = bin_of(py_reg, half_y_reg);
    assign hit_ok = bx[wxyph_pkg::HIT_IDX_W] && by[wxyph_pkg::HIT_IDX_W]
                 && (32'(bx[wxyph_pkg::HIT_IDX_W-1:0]) < 32'(BINS))
                 && (32'(by[wxyph_pkg::HIT_IDX_W-1:0]) < 32'(BINS));
    assign rd_ok  = 32'(bin_reg) < 32'(BINS);

    // transaction capture and arithmetic stages
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            x_reg    <= x_pos;
            y_reg    <= y_pos;
            bin_reg  <= bin_index;
        end
        if (cmd.mul)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (cmd.bin)
        begin
            if (kind_reg == wxyph_pkg::KIND_READ)
            begin
                x_addr_reg <= AW'(bin_reg);
                y_addr_reg <= AW'(bin_reg);
                ok_reg     <= rd_ok;
            end
            else
            begin
                x_addr_reg <= AW'(bx[wxyph_pkg::HIT_IDX_W-1:0]);
                y_addr_reg <= AW'(by[wxyph_pkg::HIT_IDX_W-1:0]);
                ok_reg     <= hit_ok;
            end
        end
    end

    // clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign stat.clear_last = clr_addr_reg == AW'(BINS - 1);

    assign x_inc = (&x_rd_reg) ? x_rd_reg : x_rd_reg + 1'b1;
    assign y_inc = (&y_rd_reg) ? y_rd_reg : y_rd_reg + 1'b1;

    assign hit_we    = cmd.commit && (kind_reg == wxyph_pkg::KIND_HIT) && ok_reg;
    assign mem_we    = cmd.clear || hit_we;
    assign x_wr_addr = cmd.clear ? clr_addr_reg : x_addr_reg;
    assign y_wr_addr = cmd.clear ? clr_addr_reg : y_addr_reg;
    assign x_wdata   = cmd.clear ? '0 : x_inc;
    assign y_wdata   = cmd.clear ? '0 : y_inc;

    // profile memories
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            x_mem[x_wr_addr] <= x_wdata;
            y_mem[y_wr_addr] <= y_wdata;
        end
        if (cmd.rd)
        begin
            x_rd_reg <= x_mem[x_addr_reg];
            y_rd_reg <= y_mem[y_addr_reg];
        end
    end

    generate
        if (COUNT_BITS > OUT_W)
        begin : g_wide
            assign x_rep = (|x_rd_reg[COUNT_BITS-1:OUT_W]) ? '1 : x_rd_reg[OUT_W-1:0];
            assign y_rep = (|y_rd_reg[COUNT_BITS-1:OUT_W]) ? '1 : y_rd_reg[OUT_W-1:0];
        end
        else
        begin : g_narrow
            assign x_rep = OUT_W'(x_rd_reg);
            assign y_rep = OUT_W'(y_rd_reg);
        end
    endgenerate

    // output registers
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            accepted_reg <= hit_we;
            if ((kind_reg == wxyph_pkg::KIND_READ) && ok_reg)
            begin
                x_count_reg <= x_rep;
                y_count_reg <= y_rep;
            end
            else
            begin
                x_count_reg <= '0;
                y_count_reg <= '0;
            end
        end
    end

    assign accepted = accepted_reg;
    assign x_count  = x_count_reg;
    assign y_count  = y_count_reg;

endmodule

// ----- src/wxyph_ctrl.sv -----
// controller: clearing pass, per transaction sequencing and output handshake
module wxyph_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output wxyph_pkg::cmd_t  cmd,
    input  wxyph_pkg::stat_t stat
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_BIN   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = 1'b1;
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_BIN;
            end
            S_BIN:
            begin
                cmd.bin    = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result committed over a pending transaction");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed result not presented");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL))
        else $error("accepted transaction not started");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL || state_reg == S_BIN || state_reg == S_READ) |-> !in_ready)
        else $error("input taken while a transaction is in flight");
`endif

endmodule

// ----- src/windowed_xy_profile_histogram_top.sv -----
// top level of the windowed xy profile histogram
//
// input channel (in_valid / in_ready) carries one transaction: kind, x_pos, y_pos, bin_index.
// kind 0 records a hit: positions (signed Q8.8) are scaled, rounded half away from zero,
// and counted in the x and y profiles if both fall strictly inside their half windows and within the profile.
// kind 1 reads both profile counts at bin_index.
// output channel (out_valid / out_ready) returns accepted, x_count, y_count, one per input.
// config port: cfg_we writes cfg_data to register cfg_index (0 scale, 1 half x, 2 half y);
// the user must do these writes only while the block is idle; the block does not enforce it.
// result: out_valid is registered on commit, after the transaction has passed the multiply, bin and read states.
// a new transaction is taken only after the last one has finished its single read-modify-write
// pass through the profile memories (multiply, bin, read, write back).
// reset: config returns to 5 / 50 / 50, then a clearing pass over every bin zeroes
// both profiles with in_ready low.
// receiver stall: a finished result holds in the output register; the next input is
// still accepted and runs until its own result is ready, then waits for out_ready.
module windowed_xy_profile_histogram_top #(
    parameter int BINS       = 128,
    parameter int COUNT_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wxyph_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wxyph_pkg::CFG_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic signed [wxyph_pkg::POS_W-1:0]  x_pos,
    input  logic signed [wxyph_pkg::POS_W-1:0]  y_pos,
    input  logic [wxyph_pkg::BIN_W-1:0]         bin_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                accepted,
    output logic [wxyph_pkg::OUT_W-1:0]         x_count,
    output logic [wxyph_pkg::OUT_W-1:0]         y_count
);

    wxyph_pkg::cmd_t  cmd;
    wxyph_pkg::stat_t stat;

    wxyph_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    wxyph_dp #(
        .BINS       (BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .kind      (kind),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .bin_index (bin_index),
        .accepted  (accepted),
        .x_count   (x_count),
        .y_count   (y_count),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ----- sim/windowed_xy_profile_histogram_top_test.sv -----
// self-checking testbench for the windowed xy profile histogram top level
`timescale 1ns / 100ps

module windowed_xy_profile_histogram_top_test;
    import wxyph_pkg::*;

    localparam int BIN_COUNT = 128;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_REQUESTS = 110;
    localparam logic [OUT_W-1:0] COUNT_FULL = '1;

    typedef struct {
        logic                    kind;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic [BIN_W-1:0]        bin_index;
    } profile_request_t;

    typedef struct {
        logic             hit_counted;
        logic [OUT_W-1:0] x_total;
        logic [OUT_W-1:0] y_total;
    } profile_reply_t;

    typedef enum int {READY_STEADY, READY_CHOPPY, READY_SPARSE} ready_mode_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    kind = KIND_HIT;
    logic signed [POS_W-1:0] x_pos = '0;
    logic signed [POS_W-1:0] y_pos = '0;
    logic [BIN_W-1:0]        bin_index = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    accepted;
    logic [OUT_W-1:0]        x_count;
    logic [OUT_W-1:0]        y_count;

    profile_request_t pending_requests[$];
    profile_reply_t   expected_replies[$];
    profile_request_t cur_request;

    logic [SCALE_W-1:0] model_scale = SCALE_RESET;
    logic [HALF_W-1:0]  model_half_x = HALF_RESET;
    logic [HALF_W-1:0]  model_half_y = HALF_RESET;
    logic [OUT_W-1:0]   x_bin_counts [BIN_COUNT];
    logic [OUT_W-1:0]   y_bin_counts [BIN_COUNT];

    int error_count = 0;
    int replies_seen = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    int segment_left = 0;
    bit long_hold_done = 1'b0;
    ready_mode_t ready_mode = READY_STEADY;

    windowed_xy_profile_histogram_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .x_pos     (x_pos),
        .y_pos     (y_pos),
        .bin_index (bin_index),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .accepted  (accepted),
        .x_count   (x_count),
        .y_count   (y_count)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic int scaled_offset(logic signed [POS_W-1:0] pos,
                                         logic [SCALE_W-1:0] scale);
        int product;
        int magnitude;
        int rounded;
        product = int'(pos) * int'(scale);
        magnitude = (product < 0) ? -product : product;
        rounded = (magnitude + 128) >> 8;
        return (product < 0) ? -rounded : rounded;
    endfunction

    function automatic void apply_request(profile_request_t req);
        profile_reply_t reply;
        int rx;
        int ry;
        int hx;
        int hy;
        reply.hit_counted = 1'b0;
        reply.x_total = '0;
        reply.y_total = '0;
        if (req.kind == KIND_HIT)
        begin
            hx = int'(model_half_x);
            hy = int'(model_half_y);
            rx = scaled_offset(req.x_pos, model_scale);
            ry = scaled_offset(req.y_pos, model_scale);
            if (rx > -hx && rx < hx && ry > -hy && ry < hy
                && rx + hx < BIN_COUNT && ry + hy < BIN_COUNT)
            begin
                if (x_bin_counts[rx + hx] != COUNT_FULL)
                    x_bin_counts[rx + hx] = x_bin_counts[rx + hx] + 1;
                if (y_bin_counts[ry + hy] != COUNT_FULL)
                    y_bin_counts[ry + hy] = y_bin_counts[ry + hy] + 1;
                reply.hit_counted = 1'b1;
            end
        end
        else
        begin
            reply.x_total = x_bin_counts[req.bin_index];
            reply.y_total = y_bin_counts[req.bin_index];
        end
        expected_replies.push_back(reply);
    endfunction

    function automatic profile_request_t make_request(logic k, int xp, int yp, int bin);
        profile_request_t req;
        req.kind = k;
        req.x_pos = POS_W'(xp);
        req.y_pos = POS_W'(yp);
        req.bin_index = BIN_W'(bin);
        return req;
    endfunction

    // position whose rounded bin offset lands around the window edge or inside it
    function automatic logic signed [POS_W-1:0] aimed_position(logic [HALF_W-1:0] half);
        int h;
        int target;
        int p;
        if (model_scale == 0)
            return POS_W'($urandom);
        h = int'(half);
        target = int'($urandom_range(0, 2 * h + 2)) - h - 1;
        p = (target * 256 + int'($urandom_range(0, 255)) - 128) / int'(model_scale);
        if (p > 32767)
            p = 32767;
        if (p < -32768)
            p = -32768;
        return POS_W'(p);
    endfunction

    function automatic profile_request_t random_request();
        profile_request_t req;
        int sel;
        sel = $urandom_range(0, 99);
        req.kind = KIND_HIT;
        req.x_pos = POS_W'($urandom);
        req.y_pos = POS_W'($urandom);
        req.bin_index = BIN_W'($urandom_range(0, BIN_COUNT - 1));
        if (sel < 30)
            req.kind = KIND_READ;
        else if (sel < 85)
        begin
            req.x_pos = aimed_position(model_half_x);
            req.y_pos = aimed_position(model_half_y);
        end
        return req;
    endfunction

    function automatic logic [HALF_W-1:0] random_half();
        case ($urandom_range(0, 9))
            0: return HALF_W'(0);
            1: return HALF_W'(1);
            2: return HALF_W'(64);
            3: return HALF_W'($urandom_range(65, 127));
            default: return HALF_W'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_SCALE:  model_scale = data[SCALE_W-1:0];
            CFG_HALF_X: model_half_x = data[HALF_W-1:0];
            CFG_HALF_Y: model_half_y = data[HALF_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int n;
        int sel;
        for (n = 0; n < BIN_COUNT; n++)
        begin
            x_bin_counts[n] = '0;
            y_bin_counts[n] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);

        // reset config: center, half rounding, window edges, extremes
        pending_requests.push_back(make_request(KIND_HIT, 0, 0, 0));
        pending_requests.push_back(make_request(KIND_HIT, 128, -128, 0));
        pending_requests.push_back(make_request(KIND_HIT, 127, -127, 0));
        pending_requests.push_back(make_request(KIND_HIT, 2509, -2509, 0));
        pending_requests.push_back(make_request(KIND_HIT, 2560, 0, 0));
        pending_requests.push_back(make_request(KIND_HIT, 0, -2560, 0));
        pending_requests.push_back(make_request(KIND_HIT, 32767, 32767, 0));
        pending_requests.push_back(make_request(KIND_HIT, -32768, -32768, 0));
        pending_requests.push_back(make_request(KIND_READ, 32767, -32768, 50));
        pending_requests.push_back(make_request(KIND_READ, 0, 0, 53));
        pending_requests.push_back(make_request(KIND_READ, -1, -1, 1));
        pending_requests.push_back(make_request(KIND_READ, 0, 0, 0));
        pending_requests.push_back(make_request(KIND_READ, 0, 0, 127));
        wait_idle();

        // zero scale puts every hit at the window center
        write_register(CFG_SCALE, CFG_W'(0));
        pending_requests.push_back(make_request(KIND_HIT, 32767, -32768, 0));
        pending_requests.push_back(make_request(KIND_HIT, -12345, 4321, 0));
        pending_requests.push_back(make_request(KIND_READ, 0, 0, 50));
        wait_idle();

        // zero half x window rejects every hit
        write_register(CFG_SCALE, CFG_W'(5));
        write_register(CFG_HALF_X, CFG_W'(0));
        pending_requests.push_back(make_request(KIND_HIT, 0, 0, 0));
        pending_requests.push_back(make_request(KIND_READ, 0, 0, 0));
        wait_idle();

        // half window past the profile end
        write_register(CFG_SCALE, CFG_W'(15));
        write_register(CFG_HALF_X, CFG_W'(127));
        write_register(CFG_HALF_Y, CFG_W'(64));
        pending_requests.push_back(make_request(KIND_HIT, 1707, 0, 0));
        pending_requests.push_back(make_request(KIND_HIT, -1707, 0, 0));
        pending_requests.push_back(make_request(KIND_HIT, 0, 1075, 0));
        pending_requests.push_back(make_request(KIND_HIT, 0, 1092, 0));
        pending_requests.push_back(make_request(KIND_READ, 0, 0, 127));
        pending_requests.push_back(make_request(KIND_READ, 0, 0, 27));
        wait_idle();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
            begin
                write_register(CFG_SCALE, CFG_W'(1));
                write_register(CFG_HALF_X, CFG_W'(64));
                write_register(CFG_HALF_Y, CFG_W'(64));
            end
            else if (phase == 1)
            begin
                write_register(CFG_SCALE, CFG_W'(15));
                write_register(CFG_HALF_X, CFG_W'(1));
                write_register(CFG_HALF_Y, CFG_W'(1));
            end
            else
            begin
                sel = $urandom_range(0, 9);
                write_register(CFG_SCALE, (sel == 0) ? CFG_W'(0) :
                               CFG_W'($urandom_range(1, 15)));
                write_register(CFG_HALF_X, CFG_W'(random_half()));
                write_register(CFG_HALF_Y, CFG_W'(random_half()));
            end
            for (n = 0; n < PHASE_REQUESTS; n++)
                pending_requests.push_back(random_request());
            wait_idle();
        end

        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("windowed_xy_profile_histogram_top regression: pass");
        else
            $display("windowed_xy_profile_histogram_top regression: fail");
        $finish;
    end

    // sender: bursts of transactions with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                apply_request(cur_request);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    cur_request = pending_requests.pop_front();
                    kind <= cur_request.kind;
                    x_pos <= cur_request.x_pos;
                    y_pos <= cur_request.y_pos;
                    bin_index <= cur_request.bin_index;
                    in_valid <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern plus one long hold-off while requests are queued
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (!long_hold_done && replies_seen >= 200 && pending_requests.size() > 40)
            begin
                hold_left = 600;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                if (segment_left <= 0)
                begin
                    segment_left = $urandom_range(10, 150);
                    ready_mode = ready_mode_t'($urandom_range(0, 2));
                end
                segment_left = segment_left - 1;
                case (ready_mode)
                    READY_STEADY: out_ready <= 1'b1;
                    READY_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
                    default:      out_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        profile_reply_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_replies.size() == 0)
            begin
                error_count++;
                if (error_count <= 100)
                    $display("%0t: unexpected transaction: accepted %0b x_count %0d y_count %0d",
                             $time, accepted, x_count, y_count);
            end
            else
            begin
                want = expected_replies.pop_front();
                replies_seen++;
                if (accepted !== want.hit_counted)
                begin
                    error_count++;
                    if (error_count <= 100)
                        $display("%0t: accepted expected %0b actual %0b",
                                 $time, want.hit_counted, accepted);
                end
                if (x_count !== want.x_total)
                begin
                    error_count++;
                    if (error_count <= 100)
                        $display("%0t: x_count expected %0d actual %0d",
                                 $time, want.x_total, x_count);
                end
                if (y_count !== want.y_total)
                begin
                    error_count++;
                    if (error_count <= 100)
                        $display("%0t: y_count expected %0d actual %0d",
                                 $time, want.y_total, y_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("windowed_xy_profile_histogram_top regression: fail");
            $finish;
        end
    end

endmodule
